// ----- rtl/hsvrgb_pkg.sv -----
// Shared types, constants and helpers for the HSV to RGB converter.
`timescale 1ns / 1ps
package hsvrgb_pkg;

   typedef logic [15:0] hue_type;
   typedef logic [7:0]  chan_type;
   typedef logic [2:0]  sector_type;

   localparam sector_type SECT_RED     = 3'd0;
   localparam sector_type SECT_YELLOW  = 3'd1;
   localparam sector_type SECT_GREEN   = 3'd2;
   localparam sector_type SECT_CYAN    = 3'd3;
   localparam sector_type SECT_BLUE    = 3'd4;
   localparam sector_type SECT_MAGENTA = 3'd5;

   localparam chan_type   CHAN_FULL  = 8'd255;
   localparam logic [15:0] ROUND_255 = 16'd127;
   localparam logic [24:0] ROUND_Q16 = 25'd32768;
   localparam logic [16:0] ONE_Q16   = 17'h10000;

   // floor(x / 255), exact for every x below 65280 (quotient fits in 8 bits)
   function automatic chan_type div255(input logic [15:0] x);
      logic [16:0] acc;
      acc = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
      return acc[15:8];
   endfunction

endpackage

// ----- rtl/hsv_to_rgb_convert.sv -----
// HSV to RGB pixel converter, five-stage pipeline.
// Each accepted req beat is registered in stages 1 through 5 in turn; stage 5 drives its rsp beat.
// Throughput: one pixel per cycle while rsp_ready is high; each stage is a small multiply, a /255 or a rounding add.
// Ready ripples back through the stage valid bits, so bubbles are squeezed out.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps
module hsv_to_rgb_convert (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hsvrgb_pkg::hue_type   req_hue,
   input  hsvrgb_pkg::chan_type  req_saturation,
   input  hsvrgb_pkg::chan_type  req_brightness,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hsvrgb_pkg::chan_type  rsp_red,
   output hsvrgb_pkg::chan_type  rsp_green,
   output hsvrgb_pkg::chan_type  rsp_blue
);
   import hsvrgb_pkg::*;

   logic [5:1] vld_ff;
   logic [5:1] vld_in;
   logic [5:1] rdy;

   // stage 1: hue*6, p numerator
   sector_type s1_sector_ff;
   logic [15:0] s1_frac_ff;
   chan_type    s1_sat_ff, s1_val_ff;
   logic [15:0] s1_pnum_ff;
   // stage 2: p, saturation products
   sector_type s2_sector_ff;
   chan_type    s2_val_ff, s2_p_ff;
   logic [24:0] s2_sfprod_ff, s2_sgprod_ff;
   // stage 3: rounded sf, sg
   sector_type s3_sector_ff;
   chan_type    s3_val_ff, s3_p_ff, s3_sf_ff, s3_sg_ff;
   // stage 4: q, t numerators
   sector_type s4_sector_ff;
   chan_type    s4_val_ff, s4_p_ff;
   logic [15:0] s4_qnum_ff, s4_tnum_ff;
   // stage 5: output
   chan_type    s5_red_ff, s5_green_ff, s5_blue_ff;

   logic [18:0] h6;
   logic [24:0] sf_sum, sg_sum;
   chan_type    q_val, t_val;
   chan_type    red_in, green_in, blue_in;

   assign rdy[5] = !vld_ff[5] || rsp_ready;
   assign rdy[4] = !vld_ff[4] || rdy[5];
   assign rdy[3] = !vld_ff[3] || rdy[4];
   assign rdy[2] = !vld_ff[2] || rdy[3];
   assign rdy[1] = !vld_ff[1] || rdy[2];

   assign req_ready = rdy[1];
   assign rsp_valid = vld_ff[5];
   assign rsp_red   = s5_red_ff;
   assign rsp_green = s5_green_ff;
   assign rsp_blue  = s5_blue_ff;

   always_comb begin
      vld_in[1] = rdy[1] ? req_valid : vld_ff[1];
      vld_in[2] = rdy[2] ? vld_ff[1] : vld_ff[2];
      vld_in[3] = rdy[3] ? vld_ff[2] : vld_ff[3];
      vld_in[4] = rdy[4] ? vld_ff[3] : vld_ff[4];
      vld_in[5] = rdy[5] ? vld_ff[4] : vld_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign h6     = {1'b0, req_hue, 2'b00} + {2'b00, req_hue, 1'b0};
   assign sf_sum = s2_sfprod_ff + ROUND_Q16;
   assign sg_sum = s2_sgprod_ff + ROUND_Q16;
   assign q_val  = div255(s4_qnum_ff);
   assign t_val  = div255(s4_tnum_ff);

   always_comb begin
      case (s4_sector_ff)
         SECT_RED: begin
            red_in = s4_val_ff;  green_in = t_val;     blue_in = s4_p_ff;
         end
         SECT_YELLOW: begin
            red_in = q_val;      green_in = s4_val_ff; blue_in = s4_p_ff;
         end
         SECT_GREEN: begin
            red_in = s4_p_ff;    green_in = s4_val_ff; blue_in = t_val;
         end
         SECT_CYAN: begin
            red_in = s4_p_ff;    green_in = q_val;     blue_in = s4_val_ff;
         end
         SECT_BLUE: begin
            red_in = t_val;      green_in = s4_p_ff;   blue_in = s4_val_ff;
         end
         default: begin
            red_in = s4_val_ff;  green_in = s4_p_ff;   blue_in = q_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_sector_ff <= h6[18:16];
         s1_frac_ff   <= h6[15:0];
         s1_sat_ff    <= req_saturation;
         s1_val_ff    <= req_brightness;
         s1_pnum_ff   <= {8'd0, req_brightness} * {8'd0, CHAN_FULL - req_saturation}
                         + ROUND_255;
      end
      if (rdy[2]) begin
         s2_sector_ff <= s1_sector_ff;
         s2_val_ff    <= s1_val_ff;
         s2_p_ff      <= div255(s1_pnum_ff);
         s2_sfprod_ff <= {9'd0, s1_frac_ff} * {17'd0, s1_sat_ff};
         s2_sgprod_ff <= {8'd0, ONE_Q16 - {1'b0, s1_frac_ff}} * {17'd0, s1_sat_ff};
      end
      if (rdy[3]) begin
         s3_sector_ff <= s2_sector_ff;
         s3_val_ff    <= s2_val_ff;
         s3_p_ff      <= s2_p_ff;
         s3_sf_ff     <= sf_sum[23:16];
         s3_sg_ff     <= sg_sum[23:16];
      end
      if (rdy[4]) begin
         s4_sector_ff <= s3_sector_ff;
         s4_val_ff    <= s3_val_ff;
         s4_p_ff      <= s3_p_ff;
         s4_qnum_ff   <= {8'd0, s3_val_ff} * {8'd0, CHAN_FULL - s3_sf_ff} + ROUND_255;
         s4_tnum_ff   <= {8'd0, s3_val_ff} * {8'd0, CHAN_FULL - s3_sg_ff} + ROUND_255;
      end
      if (rdy[5]) begin
         s5_red_ff   <= red_in;
         s5_green_ff <= green_in;
         s5_blue_ff  <= blue_in;
      end
   end

endmodule

// ----- rtl/hsvrgb_check.sv -----
// Port-level assertions for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps
module hsvrgb_check (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input hsvrgb_pkg::hue_type   req_hue,
   input hsvrgb_pkg::chan_type  req_saturation,
   input hsvrgb_pkg::chan_type  req_brightness,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input hsvrgb_pkg::chan_type  rsp_red,
   input hsvrgb_pkg::chan_type  rsp_green,
   input hsvrgb_pkg::chan_type  rsp_blue
);
   import hsvrgb_pkg::*;

   // no beat out right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid after reset");

   // input only backs up when the output is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req stalled without rsp stall");

   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue))
      else $error("rsp beat dropped or changed while stalled");

endmodule

bind hsv_to_rgb_convert hsvrgb_check u_hsvrgb_check (.*);
